FILE: sv/bnps_pkg.sv
// Package for the perturbed Boolean network step block.
// Node entry type, mode and command codes, slot layout constants.
// No dependencies.
`default_nettype none

package bnps_pkg;

	localparam int SlotCount = 4;
	localparam int SlotBits  = 7;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_TABLE = 2'd0,
		MODE_ZERO  = 2'd1,
		MODE_ONE   = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t        mode;
		logic [2:0]   count;
		logic [27:0]  sources;
		logic [15:0]  truth;
	} node_entry_t;

	// control from the handshake logic to the merge stage
	typedef struct packed {
		logic step;
		logic write;
		logic cfg;
		logic take;
	} merge_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bnps_cmd_if.sv
// Command channel: valid/ready handshake with node load, state write and step payload.
// No dependencies.
`default_nettype none

interface bnps_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [5:0]  node_index;
	logic [1:0]  node_mode;
	logic [2:0]  input_count;
	logic [27:0] input_sources;
	logic [15:0] truth_table;
	logic [63:0] vector;

	modport source (output valid, command, node_index, node_mode, input_count,
		input_sources, truth_table, vector, input ready);
	modport sink (input valid, command, node_index, node_mode, input_count,
		input_sources, truth_table, vector, output ready);
endinterface

`default_nettype wire

FILE: sv/bnps_res_if.sv
// Result channel: valid/ready handshake carrying the state vector after a step.
// No dependencies.
`default_nettype none

interface bnps_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] next_states;

	modport source (output valid, next_states, input ready);
	modport sink (input valid, next_states, output ready);
endinterface

`default_nettype wire

FILE: sv/boolean_network_perturbed_step.sv
// Step results are registered: a step's result is valid in the cycle after acceptance.
// Throughput: one transaction per cycle unless a waiting result is stalled; every node
// has its own lane, so the whole vector updates at once from the old state register.
// Ready drops only while a result waits and the result side is stalled.
// Reset clears the state vector and all node entries, active count 64.
`default_nettype none

module boolean_network_perturbed_step #(
	parameter int NODES      = 64,
	parameter int MAX_INPUTS = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [6:0] cfg_data,
	bnps_cmd_if.sink       cmd,
	bnps_res_if.source     res
);

	localparam int InLimit = (MAX_INPUTS < bnps_pkg::SlotCount) ? MAX_INPUTS
		: bnps_pkg::SlotCount;

	bnps_pkg::node_entry_t entry_q [NODES];
	bnps_pkg::merge_ctrl_t ctrl;
	logic                  res_valid;
	logic                  accept;
	logic                  load;
	logic [2:0]            cnt_sat;
	logic [NODES-1:0]      state;
	logic [NODES-1:0]      lane_bits;

	always_comb begin
		cmd.ready  = !res_valid || res.ready;
		accept     = cmd.valid && cmd.ready;
		load       = accept && cmd.command == bnps_pkg::CMD_LOAD
			&& 7'(cmd.node_index) < 7'(NODES);
		ctrl.step  = accept && cmd.command == bnps_pkg::CMD_STEP;
		ctrl.write = accept && cmd.command == bnps_pkg::CMD_WRITE;
		ctrl.cfg   = cfg_we;
		ctrl.take  = res.ready;
		cnt_sat    = (cmd.input_count > 3'(InLimit)) ? 3'(InLimit) : cmd.input_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				entry_q[i] <= '0;
		end else begin
			for (int i = 0; i < NODES; i++) begin
				if (load && cmd.node_index == 6'(i)) begin
					entry_q[i].mode    <= bnps_pkg::mode_t'(cmd.node_mode);
					entry_q[i].count   <= cnt_sat;
					entry_q[i].sources <= cmd.input_sources;
					entry_q[i].truth   <= cmd.truth_table;
				end
			end
		end
	end

	for (genvar g = 0; g < NODES; g++) begin : g_lane
		bnps_lane #(
			.NODES  (NODES),
			.INPUTS (InLimit),
			.LANE   (g)
		) u_lane (
			.entry    (entry_q[g]),
			.old      (state),
			.flip     (cmd.vector[g]),
			.bit_next (lane_bits[g])
		);
	end

	bnps_merge #(
		.NODES (NODES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg_data  (cfg_data),
		.vec       (cmd.vector),
		.lane_bits (lane_bits),
		.state     (state),
		.res_valid (res_valid),
		.res_data  (res.next_states)
	);

	assign res.valid = res_valid;

endmodule

`default_nettype wire

FILE: sv/bnps_lane.sv
// One node lane: next bit of a node from its entry and the old state vector.
// Depends on bnps_pkg.
`default_nettype none

module bnps_lane #(
	parameter int NODES  = 64,
	parameter int INPUTS = 4,
	parameter int LANE   = 0
) (
	input  var bnps_pkg::node_entry_t entry,
	input  wire logic [NODES-1:0]     old,
	input  wire logic                 flip,
	output logic                      bit_next
);

	logic [63:0] old_w;
	logic [3:0]  pattern;
	logic [6:0]  slot;
	logic        src_bit;
	logic [2:0]  sh;

	always_comb begin
		old_w   = 64'(old);
		pattern = '0;
		slot    = '0;
		src_bit = 1'b0;
		sh      = '0;
		// first input lands in the most significant used bit of the pattern
		for (int k = 0; k < INPUTS; k++) begin
			slot    = entry.sources[k*bnps_pkg::SlotBits +: bnps_pkg::SlotBits];
			src_bit = !slot[6] && old_w[slot[5:0]];
			sh      = 3'(entry.count - 3'(k + 1));
			if (3'(k) < entry.count)
				pattern = pattern | (4'(src_bit) << sh);
		end
		case (entry.mode)
			bnps_pkg::MODE_TABLE: bit_next = entry.truth[pattern];
			bnps_pkg::MODE_ZERO:  bit_next = 1'b0;
			bnps_pkg::MODE_ONE:   bit_next = 1'b1;
			bnps_pkg::MODE_HOLD:  bit_next = old[LANE];
			default:              bit_next = old[LANE];
		endcase
		if (flip)
			bit_next = !old[LANE];
	end

endmodule

`default_nettype wire

FILE: sv/bnps_merge.sv
// Merge stage: gathers lane bits into the state register, applies the active
// node mask and holds the result register. Depends on bnps_pkg.
`default_nettype none

module bnps_merge #(
	parameter int NODES = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  var bnps_pkg::merge_ctrl_t  ctrl,
	input  wire logic [6:0]            cfg_data,
	input  wire logic [63:0]           vec,
	input  wire logic [NODES-1:0]      lane_bits,
	output logic [NODES-1:0]           state,
	output logic                       res_valid,
	output logic [63:0]                res_data
);

	logic [NODES-1:0] state_q;
	logic [NODES-1:0] mask_q;
	logic [NODES-1:0] cfg_mask;
	logic [6:0]       live;
	logic [NODES-1:0] step_next;
	logic             res_valid_q;
	logic [63:0]      next_states_s1;

	always_comb begin
		live = (cfg_data > 7'(NODES)) ? 7'(NODES) : cfg_data;
		for (int i = 0; i < NODES; i++)
			cfg_mask[i] = 7'(i) < live;
		step_next = lane_bits & mask_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			mask_q      <= '1;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.step)
				state_q <= step_next;
			else if (ctrl.write)
				state_q <= vec[NODES-1:0] & mask_q;
			else if (ctrl.cfg)
				state_q <= state_q & cfg_mask;
			if (ctrl.cfg)
				mask_q <= cfg_mask;
			if (ctrl.step)
				res_valid_q <= 1'b1;
			else if (ctrl.take)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step)
			next_states_s1 <= 64'(step_next);
	end

	assign state     = state_q;
	assign res_valid = res_valid_q;
	assign res_data  = next_states_s1;

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q & ~mask_q) == '0)
		else $error("state bit set above active count");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |=> res_valid_q && next_states_s1 == 64'(state_q))
		else $error("step result does not match new state");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.write && !ctrl.step |=>
			state_q == ($past(vec[NODES-1:0]) & $past(mask_q)))
		else $error("state write not masked");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for boolean_network_perturbed_step: directed and random command streams,
// every step result checked in order against a behavioural network model.
// Depends on bnps_pkg, bnps_cmd_if and bnps_res_if.
`default_nettype none

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int Nodes       = 64;
	localparam int MaxInputs   = 4;
	localparam int RandomItems = 700;
	localparam int DrainCycles = 8;
	localparam int HoldCycles  = 250;
	localparam int CycleLimit  = 400000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;

	bnps_cmd_if cmd_if ();
	bnps_res_if res_if ();

	boolean_network_perturbed_step u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd_if),
		.res      (res_if)
	);

	// network model
	logic [63:0]           net_state;
	bnps_pkg::node_entry_t net_entry [Nodes];
	logic [6:0]            net_active;
	logic [63:0]           expected_states [$];

	int   mismatch_count;
	int   cycle_count = 0;
	int   burst_left;
	logic hold_request;
	logic hold_taken;
	int   hold_left;
	int   rcv_pct;
	int   rcv_window;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic int live_nodes();
		return (net_active > Nodes) ? Nodes : int'(net_active);
	endfunction

	function automatic logic [63:0] live_mask();
		int n;
		n = live_nodes();
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic node_next_bit(int i, logic [63:0] old);
		bnps_pkg::node_entry_t e;
		logic [3:0]  pattern;
		logic [6:0]  slot;
		int          cnt;
		e = net_entry[i];
		case (e.mode)
			bnps_pkg::MODE_ZERO: return 1'b0;
			bnps_pkg::MODE_ONE:  return 1'b1;
			bnps_pkg::MODE_HOLD: return old[i];
			default: ;
		endcase
		cnt = int'(e.count);
		pattern = '0;
		// first input lands in the most significant pattern bit
		for (int k = 0; k < cnt; k++) begin
			slot = e.sources[k*bnps_pkg::SlotBits +: bnps_pkg::SlotBits];
			pattern[cnt - 1 - k] = slot[6] ? 1'b0 : old[slot[5:0]];
		end
		return e.truth[pattern];
	endfunction

	function automatic logic [63:0] advance_network(logic [63:0] flip);
		logic [63:0] nxt;
		int          n;
		nxt = '0;
		n = live_nodes();
		for (int i = 0; i < n; i++)
			nxt[i] = flip[i] ? ~net_state[i] : node_next_bit(i, net_state);
		return nxt & live_mask();
	endfunction

	function automatic logic [27:0] random_sources(int top);
		logic [27:0] src;
		logic [6:0]  slot;
		for (int k = 0; k < bnps_pkg::SlotCount; k++) begin
			if (top == 0 || $urandom_range(0, 9) == 0)
				slot = 7'($urandom);
			else
				slot = {($urandom_range(0, 7) == 0), 6'($urandom_range(0, top - 1))};
			src[k*bnps_pkg::SlotBits +: bnps_pkg::SlotBits] = slot;
		end
		return src;
	endfunction

	// one transaction on the command channel, model updated on acceptance
	task automatic offer_command(input logic [1:0] c, input logic [5:0] idx,
			input logic [1:0] m, input logic [2:0] cnt, input logic [27:0] src,
			input logic [15:0] tt, input logic [63:0] vec);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_if.valid         <= 1'b1;
		cmd_if.command       <= c;
		cmd_if.node_index    <= idx;
		cmd_if.node_mode     <= m;
		cmd_if.input_count   <= cnt;
		cmd_if.input_sources <= src;
		cmd_if.truth_table   <= tt;
		cmd_if.vector        <= vec;
		do @(posedge clk); while (!cmd_if.ready);
		case (c)
			bnps_pkg::CMD_LOAD: begin
				net_entry[idx].mode    = bnps_pkg::mode_t'(m);
				net_entry[idx].count   = (cnt > MaxInputs) ? 3'(MaxInputs) : cnt;
				net_entry[idx].sources = src;
				net_entry[idx].truth   = tt;
			end
			bnps_pkg::CMD_WRITE: net_state = vec & live_mask();
			bnps_pkg::CMD_STEP: begin
				net_state = advance_network(vec);
				expected_states.push_back(net_state);
			end
			default: ;
		endcase
	endtask

	task automatic offer_load(input logic [5:0] idx, input logic [1:0] m,
			input logic [2:0] cnt, input logic [27:0] src, input logic [15:0] tt);
		offer_command(bnps_pkg::CMD_LOAD, idx, m, cnt, src, tt, {$urandom, $urandom});
	endtask

	task automatic offer_state(input logic [63:0] vec);
		offer_command(bnps_pkg::CMD_WRITE, 6'($urandom), 2'($urandom), 3'($urandom),
			28'($urandom), 16'($urandom), vec);
	endtask

	task automatic offer_advance(input logic [63:0] flip);
		offer_command(bnps_pkg::CMD_STEP, 6'($urandom), 2'($urandom), 3'($urandom),
			28'($urandom), 16'($urandom), flip);
	endtask

	task automatic offer_noise();
		offer_command(CMD_UNUSED, 6'($urandom), 2'($urandom), 3'($urandom), 28'($urandom),
			16'($urandom), {$urandom, $urandom});
	endtask

	// register write only once the block has drained
	task automatic set_active(input int n);
		cmd_if.valid <= 1'b0;
		while (expected_states.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= 7'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		net_active = 7'(n);
		net_state &= live_mask();
	endtask

	task automatic test_reset_state();
		offer_advance('0);
		offer_advance('1);
		offer_advance('0);
	endtask

	task automatic test_node_modes();
		offer_load(6'd0, bnps_pkg::MODE_ONE, 3'd0, 28'd0, 16'h0000);
		offer_load(6'd1, bnps_pkg::MODE_ZERO, 3'd1, 28'd0, 16'hFFFF);
		offer_load(6'd63, bnps_pkg::MODE_HOLD, 3'd2, 28'h0ABCDEF, 16'h1234);
		// four inputs: node 63, a constant, node 0, node 1
		offer_load(6'd2, bnps_pkg::MODE_TABLE, 3'd4, {7'h01, 7'h00, 7'h40, 7'h3F},
			16'h8421);
		// over-long input count, every slot a constant
		offer_load(6'd3, bnps_pkg::MODE_TABLE, 3'd7, 28'hFFFFFFF, 16'h0001);
		offer_load(6'd4, bnps_pkg::MODE_TABLE, 3'd1, 28'd0, 16'h0002);
		offer_noise();
		offer_state('1);
		offer_advance('0);
		offer_advance(64'h0000_0000_0000_00F0);
	endtask

	task automatic test_active_count();
		set_active(0);
		offer_advance('1);
		set_active(127);
		offer_state('1);
		offer_advance(64'h8000_0000_0000_0005);
		set_active(1);
		offer_advance('1);
		set_active(64);
		offer_advance('0);
	endtask

	// receiver holds off while steps keep coming, so the input side backs up
	task automatic test_pressure();
		hold_request = 1'b1;
		repeat (40)
			offer_advance(($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0);
	endtask

	task automatic test_random_network();
		int          items;
		int          live;
		int          top;
		logic [63:0] flip;
		items = 0;
		while (items < RandomItems) begin
			case ($urandom_range(0, 11))
				0:       live = 0;
				1:       live = 1;
				2:       live = 63;
				3:       live = 64;
				4:       live = $urandom_range(65, 127);
				default: live = $urandom_range(1, 64);
			endcase
			set_active(live);
			top = (live > Nodes) ? Nodes : live;
			repeat ($urandom_range(4, 20)) begin
				offer_load((top > 0 && $urandom_range(0, 7) != 0) ?
						6'($urandom_range(0, top - 1)) : 6'($urandom),
					($urandom_range(0, 9) < 6) ? bnps_pkg::MODE_TABLE
						: bnps_pkg::mode_t'($urandom_range(1, 3)),
					3'($urandom_range(0, 7)), random_sources(top), 16'($urandom));
				items++;
			end
			if ($urandom_range(0, 1) == 1) begin
				offer_state({$urandom, $urandom});
				items++;
			end
			repeat ($urandom_range(5, 30)) begin
				case ($urandom_range(0, 19))
					0: offer_noise();
					1: begin
						offer_load(6'($urandom), 2'($urandom), 3'($urandom), 28'($urandom),
							16'($urandom));
						items++;
					end
					default: begin
						case ($urandom_range(0, 9))
							0:       flip = {$urandom, $urandom};
							1, 2:    flip = 64'd1 << $urandom_range(0, 63);
							default: flip = '0;
						endcase
						offer_advance(flip);
						items++;
					end
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_taken   <= 1'b0;
			hold_left    <= 0;
			rcv_window   <= 0;
			rcv_pct      <= 100;
		end else if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_request && !hold_taken) begin
			hold_taken   <= 1'b1;
			hold_left    <= HoldCycles;
			res_if.ready <= 1'b0;
		end else begin
			if (rcv_window == 0) begin
				rcv_window <= $urandom_range(20, 120);
				case ($urandom_range(0, 4))
					0, 1:    rcv_pct <= 100;
					2:       rcv_pct <= 70;
					3:       rcv_pct <= 40;
					default: rcv_pct <= 10;
				endcase
			end else begin
				rcv_window <= rcv_window - 1;
			end
			res_if.ready <= ($urandom_range(1, 100) <= rcv_pct);
		end
	end

	always @(posedge clk) begin : check_results
		logic [63:0] want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_states.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %h",
					$time, res_if.next_states);
				mismatch_count++;
			end else begin
				want = expected_states.pop_front();
				if (res_if.next_states !== want) begin
					$display("%0t: next_states expected %h actual %h",
						$time, want, res_if.next_states);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_data             = '0;
		cmd_if.valid         = 1'b0;
		cmd_if.command       = bnps_pkg::CMD_LOAD;
		cmd_if.node_index    = '0;
		cmd_if.node_mode     = bnps_pkg::MODE_TABLE;
		cmd_if.input_count   = '0;
		cmd_if.input_sources = '0;
		cmd_if.truth_table   = '0;
		cmd_if.vector        = '0;
		hold_request         = 1'b0;
		mismatch_count       = 0;
		burst_left           = 0;
		net_state            = '0;
		net_active           = 7'd64;
		for (int i = 0; i < Nodes; i++)
			net_entry[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_node_modes();
		test_active_count();
		test_pressure();
		test_random_network();
		cmd_if.valid <= 1'b0;
		while (expected_states.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire
